@@ src/gbts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbts_pkg
// Field widths, request and status codes and the sequencer state type for the
// gap buffer text store.
// ----------------------------------------------------------------------------
package gbts_pkg;

    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 13;
    localparam int OFF_W  = 14;
    localparam int CNT_W  = 13;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 13;

    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET      = 3'd1;
    localparam logic [REQ_W-1:0] REQ_MOVE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_BACK = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_FWD  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_SETUP  = 5'b00100,
        ST_COPY   = 5'b01000,
        ST_FINISH = 5'b10000
    } gbts_state_t;

endpackage
`default_nettype wire

@@ src/gap_buffer_text_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gap_buffer_text_store
// Byte text store organized as a gap buffer, with insert, cursor set/move,
// backward/forward delete and read by logical position.
// ----------------------------------------------------------------------------
// insert, delete, read and refused requests pass through the exec and finish
//   states; a new request is taken only once the result has been issued
// set/move pass through the setup and copy states before finish (copy is skipped
//   when no byte moves), one byte copied per cycle via separate read and write ports
// reset clears the internal cursor and text length, not the cursor_pos and
//   text_length outputs; store contents stay undefined, no clearing pass is run
module gap_buffer_text_store
    import gbts_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [REQ_W-1:0]         req_type,
    input  wire  [CHAR_W-1:0]        char_in,
    input  wire  [POS_W-1:0]         position,
    input  wire  signed [OFF_W-1:0]  offset,
    input  wire  [CNT_W-1:0]         count,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [CHAR_W-1:0]        read_char,
    output logic [STAT_W-1:0]        status,
    output logic [LEN_W-1:0]         text_length,
    output logic [POS_W-1:0]         cursor_pos
);

    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int EXT_W  = ((PTR_W > OFF_W) ? PTR_W : OFF_W) + 2;

    localparam logic [PTR_W-1:0]        CAP_P = PTR_W'(CAPACITY);
    localparam logic [PTR_W:0]          CAP_W = (PTR_W + 1)'(CAPACITY);
    localparam logic signed [EXT_W-1:0] CAP_X = EXT_W'(CAPACITY);

    // text store
    logic [CHAR_W-1:0] mem [CAPACITY];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CHAR_W-1:0] rd_data_reg;

    gbts_state_t state_reg, state_next;
    logic [PTR_W-1:0]  gap_reg, gap_next;
    logic [PTR_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  target_reg, target_next;
    logic              down_reg, down_next;
    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] dst_reg, dst_next;
    logic [PTR_W-1:0]  left_reg, left_next;
    logic              pend_reg, pend_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] read_char_reg, read_char_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [LEN_W-1:0]  text_length_reg, text_length_next;
    logic [POS_W-1:0]  cursor_pos_reg, cursor_pos_next;

    // captured request
    logic [REQ_W-1:0]        req_reg;
    logic [CHAR_W-1:0]       char_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [EXT_W-1:0] gap_x, count_x, pos_x, off_x, cnt_x, after_x;
    logic signed [EXT_W-1:0] tgt_x, rd_addr_x;
    logic                    tgt_range;
    logic [PTR_W-1:0]        after_w, del_back_n, del_fwd_n, move_len;
    logic [PTR_W:0]          hi_w, hi_gap;
    logic                    in_accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;

    assign out_valid   = out_valid_reg;
    assign read_char   = read_char_reg;
    assign status      = status_reg;
    assign text_length = text_length_reg;
    assign cursor_pos  = cursor_pos_reg;

    assign gap_x   = EXT_W'(gap_reg);
    assign count_x = EXT_W'(count_reg);
    assign pos_x   = EXT_W'(pos_reg);
    assign off_x   = EXT_W'(off_reg);
    assign cnt_x   = EXT_W'(cnt_reg);

    // cursor target and its range check share one adder
    assign tgt_x     = (req_reg == REQ_SET) ? pos_x : (gap_x + off_x);
    assign tgt_range = tgt_x[EXT_W-1] || (tgt_x > count_x);

    assign del_back_n = (cnt_x < gap_x) ? PTR_W'(cnt_reg) : gap_reg;
    assign after_w    = count_reg - gap_reg;
    assign after_x    = EXT_W'(after_w);
    assign del_fwd_n  = (cnt_x < after_x) ? PTR_W'(cnt_reg) : after_w;

    // logical position past the cursor maps to the high end of the store
    assign rd_addr_x = (pos_x < gap_x) ? pos_x : (pos_x + CAP_X - count_x);

    assign hi_w     = CAP_W - {1'b0, count_reg};
    assign hi_gap   = hi_w + {1'b0, gap_reg};
    assign move_len = (target_reg < gap_reg) ? (gap_reg - target_reg)
                                             : (target_reg - gap_reg);

    always_comb
    begin
        state_next       = state_reg;
        gap_next         = gap_reg;
        count_next       = count_reg;
        target_next      = target_reg;
        down_next        = down_reg;
        src_next         = src_reg;
        dst_next         = dst_reg;
        left_next        = left_reg;
        pend_next        = pend_reg;
        stat_next        = stat_reg;
        rd_ok_next       = rd_ok_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        read_char_next   = read_char_reg;
        status_next      = status_reg;
        text_length_next = text_length_reg;
        cursor_pos_next  = cursor_pos_reg;
        mem_we           = 1'b0;
        mem_waddr        = gap_reg[ADDR_W-1:0];
        mem_wdata        = char_reg;
        mem_re           = 1'b0;
        mem_raddr        = rd_addr_x[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                stat_next  = STAT_OK;
                rd_ok_next = 1'b0;
                state_next = ST_FINISH;
                unique case (req_reg) inside
                    REQ_INSERT:
                    begin
                        if (count_reg == CAP_P)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            gap_next   = gap_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_SET, REQ_MOVE:
                    begin
                        if (tgt_range)
                        begin
                            stat_next = STAT_RANGE;
                        end
                        else
                        begin
                            target_next = tgt_x[PTR_W-1:0];
                            state_next  = ST_SETUP;
                        end
                    end
                    REQ_DEL_BACK:
                    begin
                        gap_next   = gap_reg - del_back_n;
                        count_next = count_reg - del_back_n;
                    end
                    REQ_DEL_FWD:
                    begin
                        count_next = count_reg - del_fwd_n;
                    end
                    REQ_READ:
                    begin
                        if (pos_x >= count_x)
                        begin
                            stat_next = STAT_RANGE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SETUP:
            begin
                // moving left copies top-down, moving right bottom-up
                down_next = (target_reg < gap_reg);
                left_next = move_len;
                pend_next = 1'b0;
                if (target_reg < gap_reg)
                begin
                    src_next = ADDR_W'(gap_reg - 1'b1);
                    dst_next = ADDR_W'(hi_gap - 1'b1);
                end
                else
                begin
                    src_next = hi_gap[ADDR_W-1:0];
                    dst_next = gap_reg[ADDR_W-1:0];
                end
                state_next = (move_len == '0) ? ST_FINISH : ST_COPY;
            end
            ST_COPY:
            begin
                // read of byte k overlaps write of byte k-1
                if (left_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    src_next  = down_reg ? (src_reg - 1'b1) : (src_reg + 1'b1);
                    left_next = left_reg - 1'b1;
                end
                pend_next = (left_reg != '0);
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = rd_data_reg;
                    dst_next  = down_reg ? (dst_reg - 1'b1) : (dst_reg + 1'b1);
                end
                if (left_reg == '0)
                begin
                    gap_next   = target_reg;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    read_char_next   = rd_ok_reg ? rd_data_reg : '0;
                    status_next      = stat_reg;
                    text_length_next = LEN_W'(count_reg);
                    cursor_pos_next  = POS_W'(gap_reg);
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gap_reg       <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            down_reg      <= 1'b0;
            stat_reg      <= STAT_OK;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gap_reg       <= gap_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            down_reg      <= down_next;
            stat_reg      <= stat_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg  <= req_type;
            char_reg <= char_in;
            pos_reg  <= position;
            off_reg  <= offset;
            cnt_reg  <= count;
        end
        target_reg      <= target_next;
        src_reg         <= src_next;
        dst_reg         <= dst_next;
        read_char_reg   <= read_char_next;
        status_reg      <= status_next;
        text_length_reg <= text_length_next;
        cursor_pos_reg  <= cursor_pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

`ifndef NO_ASSERTIONS
    a_gap_within_text: assert property (@(posedge clk) disable iff (!rst_n)
        gap_reg <= count_reg)
        else $error("cursor beyond text length");

    a_count_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_P)
        else $error("text length beyond capacity");

    a_copy_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && left_reg != '0) |=>
            left_reg == $past(left_reg) - 1'b1)
        else $error("copy counter did not advance");

    a_copy_last_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY && left_reg == '0) |-> pend_reg)
        else $error("copy ended without its last write");

    a_copy_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> mem_waddr != mem_raddr)
        else $error("copy read and write hit the same entry");
`endif

endmodule
`default_nettype wire
